// ===== rtl/core/fckvt_pkg.sv =====
// Package for the key/value table core: field widths, operation and status
// codes, controller states and the command word broadcast to the slot cells.
// No dependencies.
package fckvt_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int KEY_WIDTH_DEF   = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int CFG_W       = 5;
  localparam int OUT_VALUE_W = 32;
  localparam int OUT_COUNT_W = 5;

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_GET  = 2'd1,
    OP_POP  = 2'd2,
    OP_RSVD = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // Write commands for the execute cycle. Each cell qualifies them locally.
  typedef struct packed {
    logic upd;  // overwrite the value in the first matching slot
    logic ins;  // write the new pair into the slot just past the last entry
    logic pop;  // move the last entry into the first matching slot
  } cell_cmd_t;

endpackage

// ===== rtl/core/fckvt_cell.sv =====
// One slot of the key/value table: holds a key and a value, compares the
// broadcast key and passes match and last-entry data along the chain.
// Depends on fckvt_pkg.
module fckvt_cell #(
  parameter int KEY_WIDTH   = fckvt_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = fckvt_pkg::VALUE_WIDTH_DEF,
  parameter int CNT_W       = 5,
  parameter int IDX         = 0
) (
  input  logic                   clk_i,
  input  logic [KEY_WIDTH-1:0]   key_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic [CNT_W-1:0]       count_i,
  input  fckvt_pkg::cell_cmd_t   cmd_i,
  // Match chain from the lower neighbor.
  input  logic                   hit_i,
  input  logic [VALUE_WIDTH-1:0] hit_value_i,
  // Last-entry chain from the upper neighbor, since the last entry never sits
  // below the slot that it refills.
  input  logic [KEY_WIDTH-1:0]   last_key_i,
  input  logic [VALUE_WIDTH-1:0] last_value_i,
  // Match chain to the upper neighbor.
  output logic                   hit_o,
  output logic [VALUE_WIDTH-1:0] hit_value_o,
  // Last-entry chain to the lower neighbor.
  output logic [KEY_WIDTH-1:0]   last_key_o,
  output logic [VALUE_WIDTH-1:0] last_value_o
);
  import fckvt_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic                   in_use;
  logic                   is_last;
  logic                   is_tail;
  logic                   first_hit;

  assign in_use    = MY_IDX < count_i;
  assign is_last   = in_use && (MY_IDX == count_i - CNT_W'(1));
  assign is_tail   = MY_IDX == count_i;
  // Only the lowest matching slot counts, so a hit further down masks this one.
  assign first_hit = in_use && (key_q == key_i) && !hit_i;

  assign hit_o        = hit_i || first_hit;
  assign hit_value_o  = first_hit ? value_q : hit_value_i;
  assign last_key_o   = is_last ? key_q : last_key_i;
  assign last_value_o = is_last ? value_q : last_value_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd && first_hit) begin
      value_q <= value_i;
    end else if (cmd_i.ins && is_tail) begin
      key_q   <= key_i;
      value_q <= value_i;
    end else if (cmd_i.pop && first_hit) begin
      key_q   <= last_key_i;
      value_q <= last_value_i;
    end
  end

endmodule

// ===== rtl/core/fixed_capacity_key_value_table_core.sv =====
// Top level of the key/value table: controller, capacity register and the
// chain of slot cells. Depends on fckvt_pkg and fckvt_cell.
//
// The command word is captured when start is taken, and in the following
// cycle every slot compares its key at once, the first match travels up the
// cell chain and the last entry travels down it, and the slots are written
// back. The result appears on the cycle after that with done_o high for
// exactly one cycle and cannot be held off; busy is low again in that same
// cycle, so a new command may be started there; none is taken while busy.
// The capacity register accepts a write in any cycle and should be written
// only while no command is in flight.
module fixed_capacity_key_value_table_core #(
  parameter int DEPTH       = fckvt_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH   = fckvt_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = fckvt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [fckvt_pkg::OP_W-1:0]         operation_i,
  input  logic [KEY_WIDTH-1:0]               key_i,
  input  logic [VALUE_WIDTH-1:0]             value_i,
  output logic                               done_o,
  output logic [fckvt_pkg::STATUS_W-1:0]     status_o,
  output logic [fckvt_pkg::OUT_VALUE_W-1:0]  value_out_o,
  output logic [fckvt_pkg::OUT_COUNT_W-1:0]  entry_count_out_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [fckvt_pkg::CFG_W-1:0]        cfg_data_i
);
  import fckvt_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  state_e                 state_q, state_d;
  logic                   exec;
  logic                   done_q;
  op_e                    op_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CFG_W-1:0]       cap_q;
  logic [CFG_W-1:0]       cap_eff;
  status_e                status_q, status_d;
  logic [OUT_VALUE_W-1:0] value_out_q, value_out_d;
  cell_cmd_t              cmd;
  logic                   full;

  logic                   hit_chain       [DEPTH+1];
  logic [VALUE_WIDTH-1:0] hit_value_chain [DEPTH+1];
  logic [KEY_WIDTH-1:0]   last_key_chain  [DEPTH+1];
  logic [VALUE_WIDTH-1:0] last_value_chain[DEPTH+1];

  logic found;

  // Controller.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start) state_d = S_EXEC;
      S_EXEC: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b0;
    exec = 1'b0;
    unique case (state_q)
      S_IDLE: busy = 1'b0;
      S_EXEC: begin
        busy = 1'b1;
        exec = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= exec;
    end
  end

  // Command word capture.
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      op_q    <= op_e'(operation_i);
      key_q   <= key_i;
      value_q <= value_i;
    end
  end

  // Capacity register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  // A capacity of zero acts as one; one above the depth is caught by the depth check.
  assign cap_eff = (cap_q == '0) ? CFG_W'(1) : cap_q;
  assign full    = (32'(count_q) >= 32'(DEPTH)) || (32'(count_q) >= 32'(cap_eff));

  // Cell chain: the match runs from slot 0 upward, the last entry from the top down.
  assign hit_chain[0]            = 1'b0;
  assign hit_value_chain[0]      = '0;
  assign last_key_chain[DEPTH]   = '0;
  assign last_value_chain[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    fckvt_cell #(
      .KEY_WIDTH  (KEY_WIDTH),
      .VALUE_WIDTH(VALUE_WIDTH),
      .CNT_W      (CNT_W),
      .IDX        (i)
    ) u_cell (
      .clk_i       (clk_i),
      .key_i       (key_q),
      .value_i     (value_q),
      .count_i     (count_q),
      .cmd_i       (cmd),
      .hit_i       (hit_chain[i]),
      .hit_value_i (hit_value_chain[i]),
      .last_key_i  (last_key_chain[i+1]),
      .last_value_i(last_value_chain[i+1]),
      .hit_o       (hit_chain[i+1]),
      .hit_value_o (hit_value_chain[i+1]),
      .last_key_o  (last_key_chain[i]),
      .last_value_o(last_value_chain[i])
    );
  end

  assign found = hit_chain[DEPTH];

  // Execute step: write commands, result and new count.
  always_comb begin
    cmd         = '0;
    count_d     = count_q;
    status_d    = ST_OK;
    value_out_d = '0;
    if (exec) begin
      unique case (op_q)
        OP_PUSH: begin
          if (found) begin
            cmd.upd = 1'b1;
          end else if (full) begin
            status_d = ST_FULL;
          end else begin
            cmd.ins = 1'b1;
            count_d = count_q + CNT_W'(1);
          end
        end
        OP_GET: begin
          if (found) begin
            value_out_d = OUT_VALUE_W'(hit_value_chain[DEPTH]);
          end else begin
            status_d = ST_NOT_FOUND;
          end
        end
        OP_POP: begin
          if (found) begin
            cmd.pop     = 1'b1;
            value_out_d = OUT_VALUE_W'(hit_value_chain[DEPTH]);
            count_d     = count_q - CNT_W'(1);
          end else begin
            status_d = ST_NOT_FOUND;
          end
        end
        OP_RSVD: status_d = ST_OK;
        default: status_d = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      status_q    <= status_d;
      value_out_q <= value_out_d;
    end
  end

  assign done_o            = done_q;
  assign status_o          = status_q;
  assign value_out_o       = value_out_q;
  assign entry_count_out_o = OUT_COUNT_W'(count_q);

endmodule

// ===== rtl/core/fckvt_chk.sv =====
// Port-level checker for the key/value table core, with its bind statement.
// Depends on fckvt_pkg and fixed_capacity_key_value_table_core.
module fckvt_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic                              done_o,
  input logic [fckvt_pkg::STATUS_W-1:0]    status_o,
  input logic [fckvt_pkg::OUT_VALUE_W-1:0] value_out_o,
  input logic [fckvt_pkg::OUT_COUNT_W-1:0] entry_count_out_o
);
  import fckvt_pkg::*;

  // A taken command occupies the core for the next cycle.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("core not busy after a command was taken");

  // The execute cycle is followed by exactly one result word.
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> done_o && !busy)
    else $error("no result word after the execute cycle");

  a_done_only_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result word without a command");

  // A failed step returns no value and leaves the table unchanged.
  a_fail_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != ST_OK) |-> value_out_o == '0)
    else $error("nonzero value with a failed status");

  a_fail_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != ST_OK) |-> entry_count_out_o == $past(entry_count_out_o))
    else $error("entry count changed on a failed step");

endmodule

bind fixed_capacity_key_value_table_core fckvt_chk u_fckvt_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .done_o           (done_o),
  .status_o         (status_o),
  .value_out_o      (value_out_o),
  .entry_count_out_o(entry_count_out_o)
);
